// ----- rtl/alignment_backbone_finder_macros.svh -----
// Assertion macros for the backbone finder checker.
`ifndef ALIGNMENT_BACKBONE_FINDER_MACROS_SVH
`define ALIGNMENT_BACKBONE_FINDER_MACROS_SVH
// Same-cycle implication, clocked on clk, off during reset.
`define ABF_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("backbone finder check failed");
// Next-cycle implication, clocked on clk, off during reset.
`define ABF_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("backbone finder check failed");
`endif

// ----- rtl/abf_pkg.sv -----
// Package: shared types and constants of the alignment backbone finder.
package abf_pkg;
	localparam int MAX_SEQ_DEF = 8;
	localparam int POS_W       = 41;
	localparam int START_W     = 40;
	localparam int LEN_W       = 39;
	localparam int COL_W       = 32;
	localparam int GAP_W       = 32;
	localparam int CNT_W       = 4;
	localparam int IN_DATA_W   = 152;
	localparam int OUT_DATA_W  = 152;

	localparam logic [1:0] CMD_LOAD   = 2'd0;
	localparam logic [1:0] CMD_COLUMN = 2'd1;
	localparam logic [1:0] CMD_END    = 2'd2;

	localparam logic [1:0] REG_MIN_LEN = 2'd0;
	localparam logic [1:0] REG_MAX_GAP = 2'd1;
	localparam logic [1:0] REG_SEQ_CNT = 2'd2;

	localparam logic [7:0] CH_GAP = 8'h2D; // '-'
	localparam logic [7:0] CH_N   = 8'h4E; // 'N'
	localparam logic [7:0] CH_NL  = 8'h6E; // 'n'

	typedef struct packed {
		logic load;       // origin load for this lane
		logic column;     // column transaction, lane in use
		logic upd_end;    // column with no gaps: end follows position
		logic upd_start;  // new stretch opens: start takes old position
	} lane_ctl_t;

	typedef struct packed {
		logic                present;
		logic                trig;     // gap run above limit
		logic                span_ok;
		logic [START_W-1:0]  rec_start;
		logic [LEN_W-1:0]    rec_len;
	} lane_stat_t;
endpackage

// ----- rtl/alignment_backbone_finder.sv -----
// Alignment backbone finder: one lane per sequence, column at a time.
// Throughput: one input transaction per cycle while no report is pending.
// A report (stretch closed, or end of interval) emits one record per sequence in use,
// one per cycle while m_tready is high; input is taken again in the cycle the last record goes out.
// The first record is offered from a register, set by the transaction that triggers the report.
// Reset: all lane state zero, in_backbone set, registers at 50/50/8, no records.
module alignment_backbone_finder #(
	parameter int MAX_SEQUENCES = abf_pkg::MAX_SEQ_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [1:0]                       cfg_index,
	input  logic [31:0]                      cfg_data,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// seq_index[2:0], origin_start[42:3], origin_length[81:43], column_chars[145:82], zero
	input  logic [abf_pkg::IN_DATA_W-1:0]    s_tdata,
	// command[1:0]
	input  logic [1:0]                       s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// region_seq[2:0], region_start[42:3], region_length[81:43],
	// first_column[113:82], last_column[145:114], zero
	output logic [abf_pkg::OUT_DATA_W-1:0]   m_tdata,
	output logic                             m_tlast
);
	// configuration registers
	logic [31:0]               min_len_q, max_gap_q;
	logic [abf_pkg::CNT_W-1:0] seq_cnt_q, n_act;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_len_q <= 32'd50;
			max_gap_q <= 32'd50;
			seq_cnt_q <= 4'd8;
		end else if (cfg_we) begin
			unique case (cfg_index)
				abf_pkg::REG_MIN_LEN: min_len_q <= cfg_data;
				abf_pkg::REG_MAX_GAP: max_gap_q <= cfg_data;
				abf_pkg::REG_SEQ_CNT: seq_cnt_q <= cfg_data[abf_pkg::CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp sequence count into 1..MAX_SEQUENCES
	always_comb begin
		if (seq_cnt_q == '0)
			n_act = abf_pkg::CNT_W'(1);
		else if (seq_cnt_q > abf_pkg::CNT_W'(MAX_SEQUENCES))
			n_act = abf_pkg::CNT_W'(MAX_SEQUENCES);
		else
			n_act = seq_cnt_q;
	end

	// input fields
	logic [2:0]                    seq_idx;
	logic [abf_pkg::START_W-1:0]   org_start;
	logic [abf_pkg::LEN_W-1:0]     org_len;
	logic [63:0]                   chars;
	logic [abf_pkg::POS_W-1:0]     load_pos;
	logic                          acc, is_load, is_col, is_end;

	assign seq_idx   = s_tdata[2:0];
	assign org_start = s_tdata[42:3];
	assign org_len   = s_tdata[81:43];
	assign chars     = s_tdata[145:82];
	assign acc       = s_tvalid && s_tready;
	assign is_load   = acc && (s_tuser == abf_pkg::CMD_LOAD) && (32'(seq_idx) < MAX_SEQUENCES);
	assign is_col    = acc && (s_tuser == abf_pkg::CMD_COLUMN);
	assign is_end    = acc && (s_tuser == abf_pkg::CMD_END);
	// reverse strand: start minus (length plus one), 41-bit wrap
	assign load_pos  = org_start[abf_pkg::START_W-1]
		? {org_start[abf_pkg::START_W-1], org_start} - ({2'b00, org_len} + 1'b1)
		: {org_start[abf_pkg::START_W-1], org_start};

	// interval state
	logic                      in_bb_q;
	logic [abf_pkg::COL_W-1:0] col_cnt_q, first_col_q, last_col_q;

	abf_pkg::lane_stat_t stat [MAX_SEQUENCES];
	logic [MAX_SEQUENCES-1:0] active, present_v, trig_v, ok_v;
	logic no_gaps, close_hit, all_ok, fire, emit_free;

	// lanes
	for (genvar s = 0; s < MAX_SEQUENCES; s++) begin : g_lane
		abf_pkg::lane_ctl_t ctl;
		assign active[s]    = abf_pkg::CNT_W'(s) < n_act;
		assign present_v[s] = stat[s].present;
		assign trig_v[s]    = stat[s].trig;
		assign ok_v[s]      = stat[s].span_ok;
		always_comb begin
			ctl.load      = is_load && (seq_idx == 3'(s));
			ctl.column    = is_col && active[s];
			ctl.upd_end   = is_col && no_gaps;
			ctl.upd_start = is_col && no_gaps && (!in_bb_q || close_hit);
		end
		abf_lane u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.load_pos (load_pos),
			.ch       (chars[8*s +: 8]),
			.max_gap  (max_gap_q),
			.min_len  (min_len_q),
			.stat     (stat[s])
		);
	end

	// merge: gaps over lanes in use, close trigger, every span long enough
	assign no_gaps   = &(present_v | ~active);
	assign close_hit = in_bb_q && |(trig_v & present_v & active);
	assign all_ok    = &(ok_v | ~active);
	assign fire      = ((is_col && close_hit) || is_end) && all_ok;
	assign s_tready  = emit_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_bb_q     <= 1'b1;
			col_cnt_q   <= '0;
			first_col_q <= '0;
			last_col_q  <= '0;
		end else if (is_load) begin
			in_bb_q     <= 1'b1;
			col_cnt_q   <= '0;
			first_col_q <= '0;
			last_col_q  <= '0;
		end else if (is_col) begin
			col_cnt_q <= col_cnt_q + 1'b1;
			if (no_gaps) begin
				in_bb_q    <= 1'b1;
				last_col_q <= col_cnt_q;
				if (!in_bb_q || close_hit)
					first_col_q <= col_cnt_q;
			end else if (close_hit) begin
				in_bb_q <= 1'b0;
			end
		end
	end

	// record buffer and output
	abf_emit #(
		.MAX_SEQUENCES (MAX_SEQUENCES)
	) u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.n_act     (n_act),
		.stat      (stat),
		.first_col (first_col_q),
		.last_col  (last_col_q),
		.free      (emit_free),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);
endmodule

// ----- rtl/abf_lane.sv -----
// One sequence lane: position, gap run and open stretch of a sequence.
module abf_lane (
	input  logic                          clk,
	input  logic                          arst_n,
	input  abf_pkg::lane_ctl_t            ctl,
	input  logic [abf_pkg::POS_W-1:0]     load_pos,
	input  logic [7:0]                    ch,
	input  logic [abf_pkg::GAP_W-1:0]     max_gap,
	input  logic [abf_pkg::COL_W-1:0]     min_len,
	output abf_pkg::lane_stat_t           stat
);
	logic [abf_pkg::POS_W-1:0] pos_q, start_q, end_q, pos_nxt, diff;
	logic [abf_pkg::GAP_W-1:0] gap_q;
	logic                      present;

	assign present = (ch != abf_pkg::CH_GAP) && (ch != abf_pkg::CH_N) && (ch != abf_pkg::CH_NL);
	assign pos_nxt = (ctl.column && present) ? pos_q + 1'b1 : pos_q;
	assign diff    = end_q - start_q;

	always_comb begin
		stat.present   = present;
		stat.trig      = gap_q > max_gap;
		stat.span_ok   = !diff[abf_pkg::POS_W-1] &&
			(diff >= {{(abf_pkg::POS_W-abf_pkg::COL_W){1'b0}}, min_len});
		stat.rec_start = start_q[abf_pkg::POS_W-1] ? (end_q[abf_pkg::START_W-1:0] + 1'b1)
			: start_q[abf_pkg::START_W-1:0];
		stat.rec_len   = diff[abf_pkg::LEN_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			start_q <= '0;
			end_q   <= '0;
			gap_q   <= '0;
		end else if (ctl.load) begin
			pos_q   <= load_pos;
			start_q <= load_pos;
			end_q   <= load_pos;
			gap_q   <= '0;
		end else begin
			pos_q <= pos_nxt;
			if (ctl.column) begin
				if (present)
					gap_q <= '0;
				else if (gap_q != '1)
					gap_q <= gap_q + 1'b1;
			end
			if (ctl.upd_end)
				end_q <= pos_nxt;
			if (ctl.upd_start)
				start_q <= pos_q;
		end
	end
endmodule

// ----- rtl/abf_emit.sv -----
// Region record buffer: snapshots all lanes, then emits one record per cycle while m_tready is high.
module abf_emit #(
	parameter int MAX_SEQUENCES = abf_pkg::MAX_SEQ_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             fire,
	input  logic [abf_pkg::CNT_W-1:0]        n_act,
	input  abf_pkg::lane_stat_t              stat [MAX_SEQUENCES],
	input  logic [abf_pkg::COL_W-1:0]        first_col,
	input  logic [abf_pkg::COL_W-1:0]        last_col,
	output logic                             free,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// seq[2:0], start[42:3], length[81:43], first col[113:82], last col[145:114], zero
	output logic [abf_pkg::OUT_DATA_W-1:0]   m_tdata,
	output logic                             m_tlast
);
	localparam int IW = (MAX_SEQUENCES > 1) ? $clog2(MAX_SEQUENCES) : 1;

	logic [abf_pkg::START_W-1:0] start_q [MAX_SEQUENCES];
	logic [abf_pkg::LEN_W-1:0]   len_q   [MAX_SEQUENCES];
	logic [abf_pkg::COL_W-1:0]   first_q, last_q;
	logic [IW-1:0]               idx_q, top_q;
	logic                        busy_q, at_end;

	assign at_end   = idx_q == top_q;
	assign free     = !busy_q || (m_tready && at_end);
	assign m_tvalid = busy_q;
	assign m_tlast  = at_end;
	assign m_tdata  = {6'd0, last_q, first_q, len_q[idx_q], start_q[idx_q], 3'(idx_q)};

	always_ff @(posedge clk) begin
		if (fire && free) begin
			for (int s = 0; s < MAX_SEQUENCES; s++) begin
				start_q[s] <= stat[s].rec_start;
				len_q[s]   <= stat[s].rec_len;
			end
			first_q <= first_col;
			last_q  <= last_col;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
			top_q  <= '0;
		end else if (fire && free) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
			top_q  <= IW'(n_act - 1'b1);
		end else if (busy_q && m_tready) begin
			if (at_end)
				busy_q <= 1'b0;
			else
				idx_q <= idx_q + 1'b1;
		end
	end
endmodule

// ----- rtl/abf_checker.sv -----
// Port-level checker for the backbone finder, bound to the top level.
`include "alignment_backbone_finder_macros.svh"
module abf_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [abf_pkg::OUT_DATA_W-1:0] m_tdata,
	input logic                           m_tlast
);
	// a stalled record stays offered
	`ABF_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid)
	// a record that is not the last one is followed by the next sequence
	`ABF_ASSERT_NEXT(a_next_seq, m_tvalid && m_tready && !m_tlast,
		m_tvalid && (m_tdata[2:0] == $past(m_tdata[2:0]) + 3'd1))
	// input only stalls while records are pending
	`ABF_ASSERT_NOW(a_stall, !s_tready, m_tvalid)
endmodule

bind alignment_backbone_finder abf_checker u_abf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

// ----- verif/testbench.sv -----
// Testbench for the alignment backbone finder: directed and random column streams,
// checked record by record against a behavioral prediction of the block.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NSEQ = 8;
	// command code with no meaning; the block ignores it
	localparam logic [1:0] CMD_BAD = 2'd3;

	// one region record as the block emits it
	typedef struct {
		logic [2:0]  seq;
		logic [39:0] start;
		logic [38:0] len;
		logic [31:0] first_col;
		logic [31:0] last_col;
		logic        last;
	} region_rec_t;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic [1:0]                     cfg_index;
	logic [31:0]                    cfg_data;
	logic                           s_tvalid;
	logic                           s_tready;
	logic [abf_pkg::IN_DATA_W-1:0]  s_tdata;
	logic [1:0]                     s_tuser;
	logic                           m_tvalid;
	logic                           m_tready;
	logic [abf_pkg::OUT_DATA_W-1:0] m_tdata;
	logic                           m_tlast;

	alignment_backbone_finder DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	// Shadow of the block: registers and per-lane state
	logic [31:0] min_len_q;
	logic [31:0] max_gap_q;
	logic [3:0]  seq_cnt_q;
	logic [40:0] pos_q [NSEQ];
	logic [40:0] bb_start_q [NSEQ];
	logic [40:0] bb_end_q [NSEQ];
	logic [31:0] gap_q [NSEQ];
	bit          in_bb_q;
	logic [31:0] col_cnt_q;
	logic [31:0] first_col_q;
	logic [31:0] last_col_q;

	region_rec_t pending_regions[$];
	int          errors = 0;

	// sender burst shaping and receiver hold-off
	int burst_left = 0;
	bit no_idle = 0;
	int rx_hold = 0;

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		#3000000;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic int lanes_in_use();
		if (seq_cnt_q == 0)
			return 1;
		if (seq_cnt_q > NSEQ)
			return NSEQ;
		return int'(seq_cnt_q);
	endfunction

	// Backbone check: every lane in use must span at least min_len_q; if so queue records.
	function automatic void capture_backbone();
		int n;
		logic [40:0] span;
		logic [40:0] st;
		region_rec_t r;
		n = lanes_in_use();
		for (int s = 0; s < n; s++) begin
			span = bb_end_q[s] - bb_start_q[s];
			if (longint'($signed(span)) < longint'(min_len_q))
				return;
		end
		for (int s = 0; s < n; s++) begin
			st = bb_start_q[s][40] ? bb_end_q[s] + 41'd1 : bb_start_q[s];
			r.seq = s[2:0];
			r.start = st[39:0];
			r.len = 39'(bb_end_q[s] - bb_start_q[s]);
			r.first_col = first_col_q;
			r.last_col = last_col_q;
			r.last = (s == n - 1);
			pending_regions.insert(pending_regions.size(), r);
		end
	endfunction

	function automatic void predict_item(logic [1:0] cmd, logic [2:0] idx, logic [39:0] ostart,
			logic [38:0] olen, logic [63:0] chars);
		logic [40:0] p;
		logic [40:0] prev [NSEQ];
		logic [7:0] c;
		bit no_gaps;
		int n;
		case (cmd)
			abf_pkg::CMD_LOAD: begin
				p = {ostart[39], ostart};
				if (ostart[39])
					p = p - ({2'b0, olen} + 41'd1);
				pos_q[idx] = p;
				bb_start_q[idx] = p;
				bb_end_q[idx] = p;
				gap_q[idx] = 0;
				in_bb_q = 1;
				col_cnt_q = 0;
				first_col_q = 0;
				last_col_q = 0;
			end
			abf_pkg::CMD_COLUMN: begin
				n = lanes_in_use();
				no_gaps = 1;
				for (int s = 0; s < NSEQ; s++)
					prev[s] = pos_q[s];
				for (int s = 0; s < n; s++) begin
					c = chars[8*s +: 8];
					if (c != abf_pkg::CH_GAP && c != abf_pkg::CH_N && c != abf_pkg::CH_NL) begin
						// long gap closed by a present character ends the stretch
						if (gap_q[s] > max_gap_q && in_bb_q) begin
							capture_backbone();
							in_bb_q = 0;
						end
						pos_q[s] = pos_q[s] + 41'd1;
						gap_q[s] = 0;
					end else begin
						if (gap_q[s] != 32'hFFFF_FFFF)
							gap_q[s] = gap_q[s] + 1;
						no_gaps = 0;
					end
				end
				if (no_gaps) begin
					last_col_q = col_cnt_q;
					for (int s = 0; s < NSEQ; s++)
						bb_end_q[s] = pos_q[s];
					if (!in_bb_q) begin
						for (int s = 0; s < NSEQ; s++)
							bb_start_q[s] = prev[s];
						first_col_q = col_cnt_q;
						in_bb_q = 1;
					end
				end
				col_cnt_q = col_cnt_q + 1;
			end
			abf_pkg::CMD_END: capture_backbone();
			default: ;
		endcase
	endfunction

	// Send one transaction from a rising edge; returns on acceptance or after an idle gap.
	task automatic send_item(logic [1:0] cmd, logic [2:0] idx, logic [39:0] ostart,
			logic [38:0] olen, logic [63:0] chars);
		int g;
		s_tvalid <= 1;
		s_tuser <= cmd;
		s_tdata <= {6'b0, chars, olen, ostart, idx};
		do @(posedge clk); while (!s_tready);
		predict_item(cmd, idx, ostart, olen, chars);
		if (!no_idle) begin
			if (burst_left > 0) begin
				burst_left--;
			end else begin
				g = $urandom_range(1, 4);
				burst_left = $urandom_range(0, 20);
				s_tvalid <= 0;
				repeat (g) @(posedge clk);
			end
		end
	endtask

	task automatic send_load(int idx, logic [39:0] ostart, logic [38:0] olen);
		send_item(abf_pkg::CMD_LOAD, idx[2:0], ostart, olen, {$urandom, $urandom});
	endtask

	task automatic send_column(logic [63:0] chars);
		send_item(abf_pkg::CMD_COLUMN, 3'($urandom), 40'({$urandom, $urandom}),
			39'({$urandom, $urandom}), chars);
	endtask

	task automatic send_end();
		send_item(abf_pkg::CMD_END, 3'($urandom), 40'({$urandom, $urandom}),
			39'({$urandom, $urandom}), {$urandom, $urandom});
	endtask

	// Wait until every expected record is out, then let the block settle.
	task automatic drain();
		s_tvalid <= 0;
		@(posedge clk);
		while (pending_regions.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		case (idx)
			abf_pkg::REG_MIN_LEN: min_len_q = val;
			abf_pkg::REG_MAX_GAP: max_gap_q = val;
			abf_pkg::REG_SEQ_CNT: seq_cnt_q = val[3:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	function automatic logic [7:0] rand_char(int gap_pct);
		logic [7:0] c;
		if ($urandom_range(99) < gap_pct) begin
			case ($urandom_range(2))
				0: return abf_pkg::CH_GAP;
				1: return abf_pkg::CH_N;
				default: return abf_pkg::CH_NL;
			endcase
		end
		if ($urandom_range(3) == 0) begin
			do c = 8'($urandom);
			while (c == abf_pkg::CH_GAP || c == abf_pkg::CH_N || c == abf_pkg::CH_NL);
			return c;
		end
		case ($urandom_range(3))
			0: return "A";
			1: return "C";
			2: return "G";
			default: return "T";
		endcase
	endfunction

	function automatic logic [63:0] rand_column(int gap_pct);
		logic [63:0] v;
		for (int s = 0; s < NSEQ; s++)
			v[8*s +: 8] = rand_char(gap_pct);
		return v;
	endfunction

	// Receiver: stall pattern re-chosen at random from four modes, plus a counted hold-off.
	initial begin
		int phase_cnt;
		int mode;
		m_tready = 0;
		phase_cnt = 0;
		mode = 0;
		forever begin
			@(posedge clk);
			if (rx_hold > 0) begin
				rx_hold--;
				m_tready <= 0;
			end else begin
				case (mode)
					0: m_tready <= 1;
					1: m_tready <= $urandom_range(1);
					2: m_tready <= ($urandom_range(3) == 0);
					default: m_tready <= ((phase_cnt % 5) != 0);
				endcase
			end
			phase_cnt++;
			if (phase_cnt % 48 == 0)
				mode = $urandom_range(3);
		end
	end

	// Record checker: every accepted output transaction against the oldest expectation.
	always @(posedge clk) begin
		region_rec_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_regions.size() == 0) begin
				$display("%t unexpected record: actual %h last %b", $realtime, m_tdata, m_tlast);
				errors++;
			end else begin
				e = pending_regions.pop_front();
				if (m_tdata[2:0] !== e.seq) begin
					$display("%t region_seq expected %h actual %h", $realtime, e.seq, m_tdata[2:0]);
					errors++;
				end
				if (m_tdata[42:3] !== e.start) begin
					$display("%t region_start expected %h actual %h", $realtime, e.start,
						m_tdata[42:3]);
					errors++;
				end
				if (m_tdata[81:43] !== e.len) begin
					$display("%t region_length expected %h actual %h", $realtime, e.len,
						m_tdata[81:43]);
					errors++;
				end
				if (m_tdata[113:82] !== e.first_col) begin
					$display("%t first_column expected %h actual %h", $realtime, e.first_col,
						m_tdata[113:82]);
					errors++;
				end
				if (m_tdata[145:114] !== e.last_col) begin
					$display("%t last_column expected %h actual %h", $realtime, e.last_col,
						m_tdata[145:114]);
					errors++;
				end
				if (m_tlast !== e.last) begin
					$display("%t last_of_run expected %b actual %b", $realtime, e.last, m_tlast);
					errors++;
				end
			end
		end
	end

	// Reset defaults: nothing spans 50, so end of interval is silent; then report zeros.
	task automatic test_reset_state();
		send_end();
		send_item(CMD_BAD, 3'd5, '1, '1, '1); // unknown command, ignored
		drain();
		write_reg(abf_pkg::REG_MIN_LEN, 32'd0);
		write_reg(abf_pkg::REG_MAX_GAP, 32'd0);
		write_reg(abf_pkg::REG_SEQ_CNT, 32'd8);
		send_end();
		drain();
	endtask

	// Origin extremes, each gap character, stretch close after a gap, count clamping.
	task automatic test_directed();
		send_load(0, 40'h7F_FFFF_FFFF, 39'h7F_FFFF_FFFF);
		send_load(1, 40'h80_0000_0000, 39'h7F_FFFF_FFFF);
		send_load(2, 40'hFF_FFFF_FFFF, 39'd0);
		send_load(3, 40'd0, 39'd0);
		for (int s = 4; s < NSEQ; s++)
			send_load(s, 40'({$urandom, $urandom}), 39'({$urandom, $urandom}));
		send_column("AAAAAAAA");
		send_column({8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, abf_pkg::CH_NL, abf_pkg::CH_N,
			abf_pkg::CH_GAP});
		send_column(64'h0);           // present everywhere: closes after the gap
		send_column(64'hFFFF_FFFF_FFFF_FFFF);
		send_end();
		drain();
		write_reg(abf_pkg::REG_SEQ_CNT, 32'd0); // acts as one lane
		send_column({{7{abf_pkg::CH_GAP}}, 8'h41});
		send_end();
		drain();
		write_reg(abf_pkg::REG_SEQ_CNT, 32'd15); // acts as all lanes
		send_end();
		drain();
		write_reg(abf_pkg::REG_MIN_LEN, 32'hFFFF_FFFF);
		write_reg(abf_pkg::REG_MAX_GAP, 32'hFFFF_FFFF);
		send_column({8{abf_pkg::CH_N}});
		send_column("CCCCCCCC");
		send_end();
		drain();
	endtask

	// Block fills while the receiver holds off; then the sender waits for the backlog.
	task automatic test_backpressure();
		write_reg(abf_pkg::REG_MIN_LEN, 32'd0);
		write_reg(abf_pkg::REG_MAX_GAP, 32'd0);
		write_reg(abf_pkg::REG_SEQ_CNT, 32'd8);
		no_idle = 1;
		rx_hold = 200;
		for (int i = 0; i < 12; i++)
			send_column((i % 2) ? "GGGGGGGG" : {8{abf_pkg::CH_GAP}});
		no_idle = 0;
		drain();
	endtask

	// Well-formed intervals with random content, plus some noise.
	task automatic test_random_intervals();
		int items;
		int ncol;
		int gp;
		items = 0;
		while (items < 320) begin
			drain();
			write_reg(abf_pkg::REG_MIN_LEN,
				($urandom_range(9) == 0) ? $urandom : $urandom_range(0, 8));
			write_reg(abf_pkg::REG_MAX_GAP,
				($urandom_range(9) == 0) ? $urandom : $urandom_range(0, 4));
			write_reg(abf_pkg::REG_SEQ_CNT, ($urandom_range(5) == 0) ? $urandom_range(0, 15)
				: $urandom_range(1, 8));
			no_idle = ($urandom_range(3) == 0);
			for (int s = 0; s < NSEQ; s++) begin
				send_load(s, 40'({$urandom, $urandom}), ($urandom_range(3) == 0)
					? 39'({$urandom, $urandom}) : 39'($urandom_range(0, 1000)));
				items++;
			end
			ncol = $urandom_range(8, 30);
			gp = $urandom_range(0, 40);
			for (int i = 0; i < ncol; i++) begin
				case ($urandom_range(19))
					0: send_item(CMD_BAD, 3'($urandom), 40'({$urandom, $urandom}),
						39'({$urandom, $urandom}), {$urandom, $urandom});
					1: send_load($urandom_range(7), 40'({$urandom, $urandom}),
						39'({$urandom, $urandom}));
					2: send_end();
					3: send_column({$urandom, $urandom});
					default: send_column(rand_column(gp));
				endcase
				items++;
			end
			send_end();
			items++;
		end
		no_idle = 0;
		drain();
	endtask

	initial begin
		arst_n = 0;
		cfg_we = 0;
		cfg_index = 0;
		cfg_data = 0;
		s_tvalid = 0;
		s_tdata = '0;
		s_tuser = '0;
		min_len_q = 50;
		max_gap_q = 50;
		seq_cnt_q = 8;
		for (int s = 0; s < NSEQ; s++) begin
			pos_q[s] = 0;
			bb_start_q[s] = 0;
			bb_end_q[s] = 0;
			gap_q[s] = 0;
		end
		in_bb_q = 1;
		col_cnt_q = 0;
		first_col_q = 0;
		last_col_q = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);

		test_reset_state();
		test_directed();
		test_backpressure();
		test_random_intervals();

		drain();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/abf_pkg.sv
rtl/abf_lane.sv
rtl/abf_emit.sv
rtl/alignment_backbone_finder.sv
rtl/abf_checker.sv
verif/testbench.sv
